@@ rtl/etf_pkg.sv @@
package etf_pkg;

  // Frame size limits.
  localparam int MAX_FRAME_BYTES = 1518;
  localparam int MIN_FRAME_BYTES = 60;
  localparam int HDR_BYTES       = 14;

  // Field widths.
  localparam int MAC_W    = 48;
  localparam int TYPE_W   = 16;
  localparam int LEN_W    = 11;
  localparam int BYTE_W   = 8;
  localparam int STATUS_W = 2;
  localparam int HDR_W    = HDR_BYTES * BYTE_W;
  localparam int HIDX_W   = $clog2(HDR_BYTES);

  // Input item kinds.
  localparam logic CMD_HEADER  = 1'b0;
  localparam logic CMD_PAYLOAD = 1'b1;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_TOO_LONG = 2'd1,
    ST_NO_FRAME = 2'd2
  } status_t;

  // Datapath operations issued by the controller.
  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_HDR,
    OP_PAY,
    OP_PAD,
    OP_ERR
  } op_t;

  typedef struct packed {
    op_t     op;
    status_t err;
    logic    last;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic too_long;
    logic hdr_done;
    logic plen_zero;
    logic pay_last;
    logic reach_min;
  } sts_t;

endpackage

@@ rtl/etf_if.sv @@
// Request channel carrying header and payload items.
interface etf_in_if;
  logic                         valid;
  logic                         ready;
  logic                         command;
  logic [etf_pkg::MAC_W-1:0]    dest_mac;
  logic [etf_pkg::TYPE_W-1:0]   frame_type;
  logic [etf_pkg::LEN_W-1:0]    payload_length;
  logic [etf_pkg::BYTE_W-1:0]   data_byte;

  modport source (output valid, command, dest_mac, frame_type, payload_length, data_byte,
                  input ready);
  modport sink (input valid, command, dest_mac, frame_type, payload_length, data_byte,
                output ready);
endinterface

// Result channel carrying the frame byte stream.
interface etf_out_if;
  logic                         valid;
  logic                         ready;
  logic [etf_pkg::BYTE_W-1:0]   out_byte;
  logic                         last_of_run;
  logic [etf_pkg::STATUS_W-1:0] status;
  logic [etf_pkg::LEN_W-1:0]    frame_length;

  modport source (output valid, out_byte, last_of_run, status, frame_length,
                  input ready);
  modport sink (input valid, out_byte, last_of_run, status, frame_length,
                output ready);
endinterface

@@ rtl/etf_datapath.sv @@
module etf_datapath (
  input  logic                       clk,
  input  logic                       rst_n,
  input  etf_pkg::cmd_t              cmd,
  output etf_pkg::sts_t              sts,
  input  logic                       cfg_wr_en,
  input  logic [etf_pkg::MAC_W-1:0]  cfg_wr_data,
  input  logic [etf_pkg::MAC_W-1:0]  dest_mac,
  input  logic [etf_pkg::TYPE_W-1:0] frame_type,
  input  logic [etf_pkg::LEN_W-1:0]  payload_length,
  input  logic [etf_pkg::BYTE_W-1:0] data_byte,
  etf_out_if.source                  out_if
);

  logic [etf_pkg::MAC_W-1:0]    src_mac_r;
  logic [etf_pkg::HDR_W-1:0]    hdr_sr_r, hdr_sr_nxt;
  logic [etf_pkg::HIDX_W-1:0]   hdr_idx_r, hdr_idx_nxt;
  logic [etf_pkg::LEN_W-1:0]    bytes_sent_r, bytes_sent_nxt;
  logic [etf_pkg::LEN_W-1:0]    payload_left_r, payload_left_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic [etf_pkg::BYTE_W-1:0]   out_byte_r, out_byte_nxt;
  logic                         out_last_r, out_last_nxt;
  etf_pkg::status_t             out_status_r, out_status_nxt;
  logic [etf_pkg::LEN_W-1:0]    out_len_r, out_len_nxt;
  logic                         emit;

  // Status toward the controller.
  always_comb begin
    sts.out_free  = !out_valid_r || out_if.ready;
    sts.too_long  = ({1'b0, payload_length} + (etf_pkg::LEN_W+1)'(etf_pkg::HDR_BYTES))
                    > (etf_pkg::LEN_W+1)'(etf_pkg::MAX_FRAME_BYTES);
    sts.hdr_done  = hdr_idx_r == etf_pkg::HIDX_W'(etf_pkg::HDR_BYTES - 1);
    sts.plen_zero = payload_left_r == '0;
    sts.pay_last  = payload_left_r == etf_pkg::LEN_W'(1);
    sts.reach_min = ({1'b0, bytes_sent_r} + (etf_pkg::LEN_W+1)'(1))
                    >= (etf_pkg::LEN_W+1)'(etf_pkg::MIN_FRAME_BYTES);
  end

  // Frame counters, header shift register and next result.
  always_comb begin
    hdr_sr_nxt       = hdr_sr_r;
    hdr_idx_nxt      = hdr_idx_r;
    bytes_sent_nxt   = bytes_sent_r;
    payload_left_nxt = payload_left_r;
    out_byte_nxt     = '0;
    emit             = 1'b0;
    case (cmd.op)
      etf_pkg::OP_LOAD: begin
        hdr_sr_nxt       = {dest_mac, src_mac_r, frame_type};
        hdr_idx_nxt      = '0;
        bytes_sent_nxt   = '0;
        payload_left_nxt = payload_length;
      end
      etf_pkg::OP_HDR: begin
        out_byte_nxt   = hdr_sr_r[etf_pkg::HDR_W-1 -: etf_pkg::BYTE_W];
        hdr_sr_nxt     = {hdr_sr_r[etf_pkg::HDR_W-etf_pkg::BYTE_W-1:0],
                          {etf_pkg::BYTE_W{1'b0}}};
        hdr_idx_nxt    = hdr_idx_r + etf_pkg::HIDX_W'(1);
        bytes_sent_nxt = bytes_sent_r + etf_pkg::LEN_W'(1);
        emit           = 1'b1;
      end
      etf_pkg::OP_PAY: begin
        out_byte_nxt     = data_byte;
        bytes_sent_nxt   = bytes_sent_r + etf_pkg::LEN_W'(1);
        payload_left_nxt = payload_left_r - etf_pkg::LEN_W'(1);
        emit             = 1'b1;
      end
      etf_pkg::OP_PAD: begin
        bytes_sent_nxt = bytes_sent_r + etf_pkg::LEN_W'(1);
        emit           = 1'b1;
      end
      etf_pkg::OP_ERR: begin
        if (cmd.err == etf_pkg::ST_TOO_LONG) begin
          bytes_sent_nxt   = '0;
          payload_left_nxt = '0;
        end
        emit = 1'b1;
      end
      default: begin
      end
    endcase
    out_last_nxt   = cmd.last;
    out_status_nxt = cmd.err;
    out_len_nxt    = (cmd.last && cmd.op != etf_pkg::OP_ERR) ? bytes_sent_nxt : '0;
    out_valid_nxt  = emit ? 1'b1 : (out_if.ready ? 1'b0 : out_valid_r);
  end

  // Control and counter registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_mac_r      <= '0;
      hdr_idx_r      <= '0;
      bytes_sent_r   <= '0;
      payload_left_r <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        src_mac_r <= cfg_wr_data;
      end
      hdr_idx_r      <= hdr_idx_nxt;
      bytes_sent_r   <= bytes_sent_nxt;
      payload_left_r <= payload_left_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  // Result registers load only on emit; hdr_sr_r loads unconditionally.
  always_ff @(posedge clk) begin
    hdr_sr_r <= hdr_sr_nxt;
    if (emit) begin
      out_byte_r   <= out_byte_nxt;
      out_last_r   <= out_last_nxt;
      out_status_r <= out_status_nxt;
      out_len_r    <= out_len_nxt;
    end
  end

  assign out_if.valid        = out_valid_r;
  assign out_if.out_byte     = out_byte_r;
  assign out_if.last_of_run  = out_last_r;
  assign out_if.status       = out_status_r;
  assign out_if.frame_length = out_len_r;

  // A completed frame is never shorter than the minimum.
  a_min_len: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_last_r && out_status_r == etf_pkg::ST_OK) |->
    (out_len_r >= etf_pkg::LEN_W'(etf_pkg::MIN_FRAME_BYTES)))
    else $error("completed frame shorter than minimum");

  // Error results carry a zero byte, zero length and the last flag.
  a_err_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r != etf_pkg::ST_OK) |->
    (out_last_r && out_byte_r == '0 && out_len_r == '0))
    else $error("malformed error result");

  // A payload byte is only forwarded while payload remains in the frame.
  a_pay_left: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == etf_pkg::OP_PAY) |-> (payload_left_r != '0))
    else $error("payload byte forwarded with none left");

  // A new result is only produced when the output register can take it.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> sts.out_free)
    else $error("output register overwritten");

endmodule

@@ rtl/etf_ctrl.sv @@
module etf_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_command,
  output logic          in_ready,
  input  etf_pkg::sts_t sts,
  output etf_pkg::cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_OPEN,
    S_HDR,
    S_PAD
  } state_t;

  state_t state_r, state_nxt;
  logic   accept;

  // Requests are taken only while waiting and the output register is free.
  assign in_ready = (state_r == S_IDLE || state_r == S_OPEN) && sts.out_free;
  assign accept   = in_valid && in_ready;

  // Next state and datapath command.
  always_comb begin
    state_nxt = state_r;
    cmd.op    = etf_pkg::OP_NONE;
    cmd.err   = etf_pkg::ST_OK;
    cmd.last  = 1'b0;
    case (state_r)
      S_IDLE, S_OPEN: begin
        if (accept) begin
          if (in_command == etf_pkg::CMD_HEADER) begin
            if (sts.too_long) begin
              cmd.op    = etf_pkg::OP_ERR;
              cmd.err   = etf_pkg::ST_TOO_LONG;
              cmd.last  = 1'b1;
              state_nxt = S_IDLE;
            end else begin
              cmd.op    = etf_pkg::OP_LOAD;
              state_nxt = S_HDR;
            end
          end else if (state_r == S_IDLE) begin
            cmd.op   = etf_pkg::OP_ERR;
            cmd.err  = etf_pkg::ST_NO_FRAME;
            cmd.last = 1'b1;
          end else begin
            cmd.op = etf_pkg::OP_PAY;
            if (sts.pay_last) begin
              cmd.last  = sts.reach_min;
              state_nxt = sts.reach_min ? S_IDLE : S_PAD;
            end
          end
        end
      end
      S_HDR: begin
        if (sts.out_free) begin
          cmd.op = etf_pkg::OP_HDR;
          if (sts.hdr_done) begin
            if (!sts.plen_zero) begin
              state_nxt = S_OPEN;
            end else begin
              cmd.last  = sts.reach_min;
              state_nxt = sts.reach_min ? S_IDLE : S_PAD;
            end
          end
        end
      end
      S_PAD: begin
        if (sts.out_free) begin
          cmd.op = etf_pkg::OP_PAD;
          if (sts.reach_min) begin
            cmd.last  = 1'b1;
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Header and padding runs never take a request.
  a_busy_no_req: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_HDR || state_r == S_PAD) |-> !in_ready)
    else $error("request taken during header or padding run");

  // An accepted header that fits always starts a header run.
  a_hdr_start: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_command == etf_pkg::CMD_HEADER && !sts.too_long) |=>
    (state_r == S_HDR))
    else $error("header run did not start");

  // A stray payload byte leaves the frame state alone.
  a_stray_keep: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && state_r == S_IDLE && in_command == etf_pkg::CMD_PAYLOAD) |=>
    (state_r == S_IDLE))
    else $error("stray payload byte changed frame state");

endmodule

@@ rtl/ethernet_tx_framer.sv @@
// Channel  Direction  Handshake      Payload
// in_if    sink       valid/ready    command, dest_mac, frame_type, payload_length, data_byte
// out_if   source     valid/ready    out_byte, last_of_run, status, frame_length
// cfg      write      cfg_wr_en      cfg_wr_data (source MAC)
//
// A payload byte request in an open frame emits that byte; a header request loads the header and
// then emits its 14 bytes, and the last byte of a short frame is followed by zero padding bytes
// up to 60. The single output register sets the rate: a request is taken only outside header
// and padding runs and when that register is empty or being drained. Error results are one byte.
// Reset is synchronous and active low; it closes any open frame and clears the source MAC.
// When out_if.ready is low and a result is waiting, the output register holds and no request is taken.
module ethernet_tx_framer (
  input  logic                      clk,
  input  logic                      rst_n,
  etf_in_if.sink                    in_if,
  etf_out_if.source                 out_if,
  input  logic                      cfg_wr_en,
  input  logic [etf_pkg::MAC_W-1:0] cfg_wr_data
);

  etf_pkg::cmd_t cmd;
  etf_pkg::sts_t sts;

  // Frame sequencing.
  etf_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_if.valid),
    .in_command (in_if.command),
    .in_ready   (in_if.ready),
    .sts        (sts),
    .cmd        (cmd)
  );

  // Counters, header bytes and output register.
  etf_datapath u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .dest_mac       (in_if.dest_mac),
    .frame_type     (in_if.frame_type),
    .payload_length (in_if.payload_length),
    .data_byte      (in_if.data_byte),
    .out_if         (out_if)
  );

endmodule

@@ tb/sv/tb_ethernet_tx_framer.sv @@
module tb_ethernet_tx_framer;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD      = 12;
  localparam int RESET_CYCLES    = 8;
  localparam int MAX_WAIT        = 19;
  localparam int SETTLE_CYCLES   = 20;
  localparam int STALL_LIMIT     = 2000;
  localparam int RANDOM_REQUESTS = 200;
  localparam int RECONFIG_EVERY  = 60;

  localparam logic [etf_pkg::MAC_W-1:0] MAC_ZERO  = '0;
  localparam logic [etf_pkg::MAC_W-1:0] MAC_ONES  = '1;
  localparam logic [etf_pkg::MAC_W-1:0] MAC_ALT_A = 48'hAAAA_AAAA_AAAA;
  localparam logic [etf_pkg::MAC_W-1:0] MAC_ALT_5 = 48'h5555_5555_5555;

  // One expected byte of the frame stream.
  typedef struct packed {
    logic [etf_pkg::BYTE_W-1:0] data;
    logic                       last;
    etf_pkg::status_t           status;
    logic [etf_pkg::LEN_W-1:0]  length;
  } frame_result_t;

  logic                       clk;
  logic                       rst_n;
  logic                       cfg_wr_en;
  logic [etf_pkg::MAC_W-1:0]  cfg_wr_data;

  etf_in_if  in_ch ();
  etf_out_if out_ch ();

  ethernet_tx_framer dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_if       (in_ch),
    .out_if      (out_ch),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  // Predicted framer state and the stream of bytes still owed by the block.
  logic [etf_pkg::MAC_W-1:0]  station_mac;
  logic                       frame_open;
  logic [etf_pkg::LEN_W-1:0]  bytes_left;
  logic [etf_pkg::LEN_W-1:0]  bytes_sent;
  frame_result_t              expected_bytes[$];

  // When set, the matching side never idles.
  bit sender_no_gaps;
  bit receiver_no_stalls;

  int errors;
  int n_headers;
  int n_payloads;
  int n_checked;
  int n_frames;
  int n_too_long;
  int n_no_frame;
  int idle_cycles;

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  function automatic logic [etf_pkg::MAC_W-1:0] rand_mac();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[etf_pkg::MAC_W-1:0];
  endfunction

  function automatic void push_result(logic [etf_pkg::BYTE_W-1:0] b, logic last,
                                      etf_pkg::status_t st,
                                      logic [etf_pkg::LEN_W-1:0] len);
    frame_result_t r;
    r.data   = b;
    r.last   = last;
    r.status = st;
    r.length = len;
    expected_bytes.push_back(r);
  endfunction

  // Zero bytes up to the minimum frame size; the byte that reaches it closes the frame.
  function automatic void pad_and_close();
    while (bytes_sent < etf_pkg::LEN_W'(etf_pkg::MIN_FRAME_BYTES)) begin
      bytes_sent = bytes_sent + etf_pkg::LEN_W'(1);
      if (bytes_sent == etf_pkg::LEN_W'(etf_pkg::MIN_FRAME_BYTES)) begin
        push_result('0, 1'b1, etf_pkg::ST_OK, bytes_sent);
      end else begin
        push_result('0, 1'b0, etf_pkg::ST_OK, '0);
      end
    end
    frame_open = 1'b0;
    bytes_left = '0;
    n_frames++;
  endfunction

  // Works out every byte that one accepted request makes the framer emit.
  function automatic void predict_frame_bytes(logic cmd, logic [etf_pkg::MAC_W-1:0] dst,
                                              logic [etf_pkg::TYPE_W-1:0] typ,
                                              logic [etf_pkg::LEN_W-1:0] plen,
                                              logic [etf_pkg::BYTE_W-1:0] data);
    logic closing;
    if (cmd == etf_pkg::CMD_HEADER) begin
      n_headers++;
      if (int'(plen) + etf_pkg::HDR_BYTES > etf_pkg::MAX_FRAME_BYTES) begin
        // Oversize frame: reject it and drop whatever frame was open.
        frame_open = 1'b0;
        bytes_left = '0;
        bytes_sent = '0;
        push_result('0, 1'b1, etf_pkg::ST_TOO_LONG, '0);
        n_too_long++;
      end else begin
        for (int i = 5; i >= 0; i--) push_result(dst[8*i +: 8], 1'b0, etf_pkg::ST_OK, '0);
        for (int i = 5; i >= 0; i--) begin
          push_result(station_mac[8*i +: 8], 1'b0, etf_pkg::ST_OK, '0);
        end
        push_result(typ[15:8], 1'b0, etf_pkg::ST_OK, '0);
        push_result(typ[7:0], 1'b0, etf_pkg::ST_OK, '0);
        bytes_sent = etf_pkg::LEN_W'(etf_pkg::HDR_BYTES);
        bytes_left = plen;
        frame_open = 1'b1;
        if (plen == '0) pad_and_close();
      end
    end else begin
      n_payloads++;
      if (!frame_open) begin
        push_result('0, 1'b1, etf_pkg::ST_NO_FRAME, '0);
        n_no_frame++;
      end else begin
        bytes_sent = bytes_sent + etf_pkg::LEN_W'(1);
        bytes_left = bytes_left - etf_pkg::LEN_W'(1);
        closing    = (bytes_left == '0) &&
                     (bytes_sent >= etf_pkg::LEN_W'(etf_pkg::MIN_FRAME_BYTES));
        push_result(data, closing, etf_pkg::ST_OK, closing ? bytes_sent : '0);
        if (bytes_left == '0) pad_and_close();
      end
    end
  endfunction

  // Sends one request after a random gap; valid stays high until the next call decides.
  task automatic send_request(logic cmd, logic [etf_pkg::MAC_W-1:0] dst,
                              logic [etf_pkg::TYPE_W-1:0] typ,
                              logic [etf_pkg::LEN_W-1:0] plen,
                              logic [etf_pkg::BYTE_W-1:0] data);
    int gap;
    gap = sender_no_gaps ? 0 : $urandom_range(0, MAX_WAIT);
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.command        = cmd;
    in_ch.dest_mac       = dst;
    in_ch.frame_type     = typ;
    in_ch.payload_length = plen;
    in_ch.data_byte      = data;
    in_ch.valid          = 1'b1;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    predict_frame_bytes(cmd, dst, typ, plen, data);
  endtask

  // Header request; the unused data byte carries noise.
  task automatic send_header(logic [etf_pkg::MAC_W-1:0] dst, logic [etf_pkg::TYPE_W-1:0] typ,
                             logic [etf_pkg::LEN_W-1:0] plen);
    send_request(etf_pkg::CMD_HEADER, dst, typ, plen, etf_pkg::BYTE_W'($urandom));
  endtask

  // Payload request; the unused header fields carry noise.
  task automatic send_payload(logic [etf_pkg::BYTE_W-1:0] data);
    send_request(etf_pkg::CMD_PAYLOAD, rand_mac(), etf_pkg::TYPE_W'($urandom),
                 etf_pkg::LEN_W'($urandom), data);
  endtask

  // Stops sending and waits until every expected byte has come out.
  task automatic wait_for_idle();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Register write; only called while the framer is idle.
  task automatic write_station_mac(logic [etf_pkg::MAC_W-1:0] value);
    @(negedge clk);
    cfg_wr_en   = 1'b1;
    cfg_wr_data = value;
    @(negedge clk);
    cfg_wr_en   = 1'b0;
    station_mac = value;
  endtask

  // Reset leaves no frame open and a zero station MAC.
  task automatic test_reset_state();
    send_payload(8'hFF);
    send_payload(8'h00);
    send_header(MAC_ONES, 16'hFFFF, 11'd0);
    wait_for_idle();
  endtask

  // Station MAC of all ones, header fields of all zeros, payload bytes at both extremes.
  task automatic test_station_mac_extremes();
    write_station_mac(MAC_ONES);
    send_header(MAC_ZERO, 16'h0000, 11'd0);
    send_header(48'h0123_4567_89AB, 16'h0800, 11'd2);
    send_payload(8'h00);
    send_payload(8'hFF);
    wait_for_idle();
  endtask

  // Largest legal frame, the first oversize one and the largest length field.
  task automatic test_length_limits();
    send_header(rand_mac(), etf_pkg::TYPE_W'($urandom),
                etf_pkg::LEN_W'(etf_pkg::MAX_FRAME_BYTES - etf_pkg::HDR_BYTES));
    send_header(rand_mac(), etf_pkg::TYPE_W'($urandom),
                etf_pkg::LEN_W'(etf_pkg::MAX_FRAME_BYTES - etf_pkg::HDR_BYTES + 1));
    send_payload(8'h5A);
    send_header(rand_mac(), etf_pkg::TYPE_W'($urandom), 11'h7FF);
    send_header(rand_mac(), etf_pkg::TYPE_W'($urandom), 11'd1);
    send_payload(8'hA5);
    wait_for_idle();
  endtask

  // A new header while a frame is open abandons the old frame.
  task automatic test_abandoned_frame();
    send_header(rand_mac(), etf_pkg::TYPE_W'($urandom), 11'd5);
    send_payload(etf_pkg::BYTE_W'($urandom));
    send_payload(etf_pkg::BYTE_W'($urandom));
    send_header(rand_mac(), etf_pkg::TYPE_W'($urandom), 11'd3);
    repeat (3) send_payload(etf_pkg::BYTE_W'($urandom));
    wait_for_idle();
  endtask

  // Mostly short frames, with a share right around the padding boundary.
  function automatic int pick_payload_length();
    int r;
    r = $urandom_range(0, 9);
    if (r <= 3) return $urandom_range(1, 6);
    if (r == 4) return 0;
    if (r <= 6) return $urandom_range(etf_pkg::MIN_FRAME_BYTES - etf_pkg::HDR_BYTES - 2,
                                      etf_pkg::MIN_FRAME_BYTES - etf_pkg::HDR_BYTES + 2);
    if (r <= 8) return $urandom_range(7, 30);
    return $urandom_range(49, 70);
  endfunction

  // Random traffic: well-formed frames plus abandoned frames, oversize headers and strays.
  task automatic test_random_traffic();
    int sent;
    int kind;
    int plen;
    int cut;
    int next_reconfig;
    int reconfigs;
    sent          = 0;
    next_reconfig = RECONFIG_EVERY;
    reconfigs     = 0;
    while (sent < RANDOM_REQUESTS) begin
      if ($urandom_range(0, 7) == 0) begin
        sender_no_gaps     = ($urandom_range(0, 2) == 0);
        receiver_no_stalls = ($urandom_range(0, 2) == 0);
      end
      kind = $urandom_range(0, 99);
      if (kind < 72) begin
        plen = pick_payload_length();
        send_header(rand_mac(), etf_pkg::TYPE_W'($urandom), etf_pkg::LEN_W'(plen));
        repeat (plen) send_payload(etf_pkg::BYTE_W'($urandom));
        sent += plen + 1;
      end else if (kind < 84) begin
        plen = ($urandom_range(0, 3) == 0)
               ? $urandom_range(100, etf_pkg::MAX_FRAME_BYTES - etf_pkg::HDR_BYTES)
               : $urandom_range(2, 40);
        cut  = $urandom_range(0, (plen - 1 < 6) ? plen - 1 : 6);
        send_header(rand_mac(), etf_pkg::TYPE_W'($urandom), etf_pkg::LEN_W'(plen));
        repeat (cut) send_payload(etf_pkg::BYTE_W'($urandom));
        sent += cut + 1;
      end else if (kind < 92) begin
        send_header(rand_mac(), etf_pkg::TYPE_W'($urandom),
                    etf_pkg::LEN_W'($urandom_range(
                      etf_pkg::MAX_FRAME_BYTES - etf_pkg::HDR_BYTES + 1, 2047)));
        sent++;
      end else begin
        send_payload(etf_pkg::BYTE_W'($urandom));
        sent++;
      end

      // Drain fully now and then and move the station MAC to a new value.
      if (sent >= next_reconfig) begin
        wait_for_idle();
        case (reconfigs % 3)
          0:       write_station_mac(MAC_ALT_A);
          1:       write_station_mac(rand_mac());
          default: write_station_mac(MAC_ALT_5);
        endcase
        reconfigs++;
        next_reconfig += RECONFIG_EVERY;
      end
    end
  endtask

  // Result side: random stall before each byte is taken.
  initial begin : result_sink
    int stall;
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      stall = receiver_no_stalls ? 0 : $urandom_range(0, MAX_WAIT);
      if (stall > 0) begin
        out_ch.ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready = 1'b1;
      do @(posedge clk); while (out_ch.valid !== 1'b1);
    end
  end

  // Compare every byte taken against the oldest prediction.
  always @(posedge clk) begin : check_results
    frame_result_t want;
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (expected_bytes.size() == 0) begin
        errors++;
        $display("%0t: unexpected result: byte %h last %b status %0d length %0d", $time,
                 out_ch.out_byte, out_ch.last_of_run, out_ch.status, out_ch.frame_length);
      end else begin
        want = expected_bytes.pop_front();
        n_checked++;
        if (out_ch.out_byte !== want.data) begin
          errors++;
          $display("%0t: out_byte expected %h actual %h", $time, want.data, out_ch.out_byte);
        end
        if (out_ch.last_of_run !== want.last) begin
          errors++;
          $display("%0t: last_of_run expected %b actual %b", $time, want.last,
                   out_ch.last_of_run);
        end
        if (out_ch.status !== want.status) begin
          errors++;
          $display("%0t: status expected %0d actual %0d", $time, want.status, out_ch.status);
        end
        if (out_ch.frame_length !== want.length) begin
          errors++;
          $display("%0t: frame_length expected %0d actual %0d", $time, want.length,
                   out_ch.frame_length);
        end
      end
    end
  end

  // Give up if neither side moves a request or result for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
        (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: nothing moved for %0d cycles, %0d bytes still expected", $time,
               STALL_LIMIT, expected_bytes.size());
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Main sequence.
  initial begin
    errors             = 0;
    n_headers          = 0;
    n_payloads         = 0;
    n_checked          = 0;
    n_frames           = 0;
    n_too_long         = 0;
    n_no_frame         = 0;
    idle_cycles        = 0;
    sender_no_gaps     = 1'b0;
    receiver_no_stalls = 1'b0;
    station_mac        = '0;
    frame_open         = 1'b0;
    bytes_left         = '0;
    bytes_sent         = '0;

    in_ch.valid          = 1'b0;
    in_ch.command        = etf_pkg::CMD_HEADER;
    in_ch.dest_mac       = '0;
    in_ch.frame_type     = '0;
    in_ch.payload_length = '0;
    in_ch.data_byte      = '0;
    cfg_wr_en            = 1'b0;
    cfg_wr_data          = '0;
    rst_n                = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_reset_state();
    test_station_mac_extremes();
    test_length_limits();
    test_abandoned_frame();
    test_random_traffic();
    wait_for_idle();

    $display("Drove %0d header and %0d payload requests; checked %0d frame bytes.",
             n_headers, n_payloads, n_checked);
    $display("Closed %0d frames, %0d oversize headers, %0d stray payload bytes, %0d mismatches.",
             n_frames, n_too_long, n_no_frame, errors);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/etf_pkg.sv
rtl/etf_if.sv
rtl/etf_datapath.sv
rtl/etf_ctrl.sv
rtl/ethernet_tx_framer.sv
tb/sv/tb_ethernet_tx_framer.sv
